@@ hdl/best_fit_range_allocator_defines.svh @@
// assertion macros used by the allocator top module
// no dependencies
`ifndef BEST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BFRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define BFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/bfra_pkg.sv @@
// shared types, constants and codes of the best-fit range allocator
// no dependencies
package bfra_pkg;
    localparam int unsigned MAX_FREE_RANGES_DEF = 64;
    localparam int unsigned MAX_USED_BLOCKS_DEF = 64;
    localparam int unsigned OFFSET_BITS = 32;
    localparam logic [32:0] HEAP_RESET = 33'd1048576;
    localparam logic [32:0] GRANULE = 33'd16;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_RESIZE = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_ARG = 3'd1;
    localparam logic [2:0] ST_NO_FIT = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
    localparam logic [2:0] ST_NO_GROW = 3'd5;
    localparam logic [2:0] ST_FULL = 3'd6;

    typedef struct packed {
        logic [1:0] func;
        logic [31:0] block_offset;
        logic [31:0] request_size;
        logic [31:0] alignment;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] result_offset;
        logic [31:0] block_size;
        logic [31:0] used_bytes;
    } t_rsp;

    // one table entry as it moves down the row of cells
    typedef struct packed {
        logic vld;
        logic [32:0] start;
        logic [32:0] len;
    } t_ent;

    // command from the controller to every cell of a row
    typedef struct packed {
        logic clr;       // clear the row; cell 0 of the free row holds the whole heap
        logic wr;        // write entry at position wr_pos
        logic [9:0] wr_pos;
        t_ent wr_ent;
        logic shift;     // rotate the row by one
    } t_cell_cmd;
endpackage

@@ hdl/best_fit_range_allocator.sv @@
// best-fit range allocator: controller over two rings of table cells
// depends on bfra_pkg, bfra_row, bfra_cell and best_fit_range_allocator_defines.svh
// Uses i_req (t_req beat, valid/ready) and o_rsp (t_rsp beat, valid/ready).
// One request is taken at a time. Each request walks the used ring once
// and then the free ring once; both rings rotate one cell per cycle and
// come back to their home position. A decide state follows, then a state
// for a second free-table write, after which the controller is back in idle
// and can take the next request.
// The result sits in an output register; while the receiver stalls the next
// request is still taken and walked, and it waits in the decide state until the
// output register is free. o_req_ready stays low meanwhile.
// Reset (synchronous, low) gives one free range [0, 1048576) and no used blocks.
// i_cfg_we writes heap_size (saturated to 16 .. 2^32-16) and reinitializes
// the tables the same way; write only while idle.
// Entries are tracked in ring position, so a new entry always goes into the
// first empty slot seen in the walk.
module best_fit_range_allocator
    import bfra_pkg::*;
#(
    parameter int unsigned MAX_FREE_RANGES = MAX_FREE_RANGES_DEF,
    parameter int unsigned MAX_USED_BLOCKS = MAX_USED_BLOCKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  bfra_pkg::t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output bfra_pkg::t_rsp o_rsp,
    input  logic i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    `include "best_fit_range_allocator_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_USCAN = 3'd1;
    localparam logic [2:0] S_FSCAN = 3'd2;
    localparam logic [2:0] S_DEC = 3'd3;
    localparam logic [2:0] S_FIN = 3'd4;

    logic [2:0] r_st, n_st;
    t_req r_req;
    logic [32:0] r_heap, r_used_bytes;
    logic [10:0] r_cnt;
    t_rsp r_rsp;
    logic r_rsp_vld;

    // scan results
    logic r_u_hit, r_u_slot_ok;
    logic [9:0] r_u_idx, r_u_slot;
    logic [32:0] r_u_len;
    logic r_f_slot_ok, r_prev_ok, r_next_ok, r_best_ok;
    logic [9:0] r_f_slot, r_prev, r_next, r_best;
    logic [32:0] r_prev_len, r_next_len, r_best_start, r_best_len, r_best_skip;

    t_cell_cmd w_fcmd, w_ucmd;
    t_ent w_fh, w_uh;
    logic [32:0] w_init_len;

    // request decode
    logic [32:0] w_off, w_req, w_al, w_need, w_alm1;
    assign w_off = {1'b0, r_req.block_offset};
    assign w_req = {1'b0, r_req.request_size};
    assign w_al = {1'b0, r_req.alignment};
    assign w_alm1 = w_al - 33'd1;
    assign w_need = (w_req + 33'd15) & ~33'd15;

    // heap size saturation
    always_comb begin
        if (i_cfg_data < 32'd16) w_init_len = GRANULE;
        else if (i_cfg_data > 32'hFFFF_FFF0) w_init_len = 33'hFFFF_FFF0;
        else w_init_len = {1'b0, i_cfg_data};
    end

    bfra_row #(.DEPTH(MAX_FREE_RANGES), .INIT_VLD(1'b1)) u_free (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_fcmd),
        .i_init_len(w_init_len), .o_head(w_fh)
    );
    bfra_row #(.DEPTH(MAX_USED_BLOCKS), .INIT_VLD(1'b0)) u_used (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_ucmd),
        .i_init_len(w_init_len), .o_head(w_uh)
    );

    // free head evaluation for the allocate fit
    logic [32:0] w_skip, w_fend;
    logic w_fit, w_better;
    assign w_skip = ((w_fh.start + w_alm1) & ~w_alm1) - w_fh.start;
    assign w_fit = w_fh.vld && w_fh.len >= w_need && w_fh.len >= w_need + w_skip;
    assign w_better = !r_best_ok || w_fh.len < r_best_len
        || (w_fh.len == r_best_len && w_fh.start < r_best_start);
    assign w_fend = w_fh.start + w_fh.len;

    logic w_in_acc, w_out_acc, w_dec_go;
    assign o_req_ready = (r_st == S_IDLE);
    assign w_in_acc = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_vld;
    assign w_out_acc = o_rsp_valid && i_rsp_ready;
    assign o_rsp = r_rsp;
    // decide only once the output register is free or being drained
    assign w_dec_go = (r_st == S_DEC) && (!r_rsp_vld || i_rsp_ready);

    // decision stage signals
    t_rsp d_rsp;
    logic [32:0] d_used;
    t_ent d_fe1, d_fe2, d_ue;
    logic d_fw1, d_fw2, d_uw;
    logic [9:0] d_fp1, d_fp2, d_up;
    logic [32:0] w_tail, w_end, w_relsz, w_delta;
    logic w_is_rel;

    always_comb begin
        d_rsp = '0;
        d_used = r_used_bytes;
        d_fw1 = 1'b0; d_fw2 = 1'b0; d_uw = 1'b0;
        d_fp1 = '0; d_fp2 = '0; d_up = '0;
        d_fe1 = '0; d_fe2 = '0; d_ue = '0;
        w_tail = r_best_len - r_best_skip - w_need;
        w_end = w_off + r_u_len;
        w_relsz = r_u_len;
        w_delta = '0;
        w_is_rel = (r_req.func == FUNC_RELEASE)
            || (r_req.func == FUNC_RESIZE && w_req == '0);
        if (r_req.func == FUNC_ALLOC) begin
            if (w_req == '0 || w_req > r_heap || w_al == '0 || (w_al & w_alm1) != '0) begin
                d_rsp.status = ST_BAD_ARG;
            end else if (!r_best_ok) begin
                d_rsp.status = ST_NO_FIT;
            end else if (!r_u_slot_ok
                || (r_best_skip != '0 && w_tail != '0 && !r_f_slot_ok)) begin
                d_rsp.status = ST_FULL;
            end else begin
                d_fw1 = 1'b1;
                d_fp1 = r_best;
                if (r_best_skip != '0) begin
                    d_fe1 = '{1'b1, r_best_start, r_best_skip};
                    if (w_tail != '0) begin
                        d_fw2 = 1'b1;
                        d_fp2 = r_f_slot;
                        d_fe2 = '{1'b1, r_best_start + r_best_skip + w_need, w_tail};
                    end
                end else if (w_tail != '0) begin
                    d_fe1 = '{1'b1, r_best_start + w_need, w_tail};
                end else begin
                    d_fe1 = '0;
                end
                d_uw = 1'b1;
                d_up = r_u_slot;
                d_ue = '{1'b1, r_best_start + r_best_skip, w_need};
                d_used = r_used_bytes + w_need;
                d_rsp.status = ST_OK;
                d_rsp.result_offset = 32'(r_best_start + r_best_skip);
                d_rsp.block_size = 32'(w_need);
            end
        end else if (w_off >= r_heap) begin
            d_rsp.status = ST_RANGE;
        end else if (!r_u_hit) begin
            d_rsp.status = ST_NOT_ALLOC;
        end else if (r_req.func == FUNC_QUERY) begin
            d_rsp.status = ST_OK;
            d_rsp.block_size = 32'(r_u_len);
        end else if (w_is_rel) begin
            if (!r_prev_ok && !r_next_ok && !r_f_slot_ok) begin
                d_rsp.status = ST_FULL;
            end else begin
                if (r_prev_ok) begin
                    d_fw1 = 1'b1; d_fp1 = r_prev;
                    d_fe1 = '{1'b1, w_off - r_prev_len,
                        r_prev_len + w_relsz + (r_next_ok ? r_next_len : 33'd0)};
                    if (r_next_ok) begin
                        d_fw2 = 1'b1; d_fp2 = r_next; d_fe2 = '0;
                    end
                end else if (r_next_ok) begin
                    d_fw1 = 1'b1; d_fp1 = r_next;
                    d_fe1 = '{1'b1, w_off, r_next_len + w_relsz};
                end else begin
                    d_fw1 = 1'b1; d_fp1 = r_f_slot;
                    d_fe1 = '{1'b1, w_off, w_relsz};
                end
                d_uw = 1'b1; d_up = r_u_idx; d_ue = '0;
                d_used = (w_relsz > r_used_bytes) ? '0 : r_used_bytes - w_relsz;
                d_rsp.status = ST_OK;
                d_rsp.block_size = 32'(w_relsz);
            end
        end else if (w_req < r_u_len) begin
            w_delta = r_u_len - w_req;
            if (!r_next_ok && !r_f_slot_ok) begin
                d_rsp.status = ST_FULL;
            end else begin
                d_fw1 = 1'b1;
                d_fp1 = r_next_ok ? r_next : r_f_slot;
                d_fe1 = '{1'b1, w_off + w_req,
                    (r_next_ok ? r_next_len : 33'd0) + w_delta};
                d_uw = 1'b1; d_up = r_u_idx; d_ue = '{1'b1, w_off, w_req};
                d_used = (w_delta > r_used_bytes) ? '0 : r_used_bytes - w_delta;
                d_rsp.status = ST_OK;
                d_rsp.block_size = 32'(w_req);
            end
        end else if (w_req > r_u_len) begin
            w_delta = w_req - r_u_len;
            if (!r_next_ok || r_next_len < w_delta) begin
                d_rsp.status = ST_NO_GROW;
            end else begin
                d_fw1 = 1'b1; d_fp1 = r_next;
                d_fe1 = (r_next_len == w_delta) ? '0
                    : '{1'b1, w_end + w_delta, r_next_len - w_delta};
                d_uw = 1'b1; d_up = r_u_idx; d_ue = '{1'b1, w_off, w_req};
                d_used = r_used_bytes + w_delta;
                d_rsp.status = ST_OK;
                d_rsp.block_size = 32'(w_req);
            end
        end else begin
            d_rsp.status = ST_OK;
            d_rsp.block_size = 32'(w_req);
        end
        d_rsp.used_bytes = 32'(d_used);
    end

    // second free write lands in the cycle after the first
    logic r_fw2;
    logic [9:0] r_fp2;
    t_ent r_fe2;

    always_comb begin
        w_fcmd = '0;
        w_ucmd = '0;
        w_fcmd.clr = i_cfg_we;
        w_ucmd.clr = i_cfg_we;
        w_fcmd.shift = (r_st == S_FSCAN);
        w_ucmd.shift = (r_st == S_USCAN);
        if (w_dec_go) begin
            w_fcmd.wr = d_fw1; w_fcmd.wr_pos = d_fp1; w_fcmd.wr_ent = d_fe1;
            w_ucmd.wr = d_uw;  w_ucmd.wr_pos = d_up;  w_ucmd.wr_ent = d_ue;
        end else if (r_st == S_FIN && r_fw2) begin
            w_fcmd.wr = 1'b1; w_fcmd.wr_pos = r_fp2; w_fcmd.wr_ent = r_fe2;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (w_in_acc) n_st = S_USCAN;
            S_USCAN: if (r_cnt == 11'(MAX_USED_BLOCKS - 1)) n_st = S_FSCAN;
            S_FSCAN: if (r_cnt == 11'(MAX_FREE_RANGES - 1)) n_st = S_DEC;
            S_DEC: if (w_dec_go) n_st = S_FIN;
            S_FIN: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_heap <= HEAP_RESET;
            r_used_bytes <= '0;
            r_cnt <= '0;
            r_fw2 <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                r_heap <= w_init_len;
                r_used_bytes <= '0;
            end
            if (w_in_acc) r_req <= i_req;
            if (r_st == S_USCAN && r_cnt != 11'(MAX_USED_BLOCKS - 1)) r_cnt <= r_cnt + 11'd1;
            else if (r_st == S_FSCAN && r_cnt != 11'(MAX_FREE_RANGES - 1))
                r_cnt <= r_cnt + 11'd1;
            else r_cnt <= '0;
            if (w_dec_go) begin
                r_rsp <= d_rsp;
                r_used_bytes <= d_used;
                r_fw2 <= d_fw2; r_fp2 <= d_fp2; r_fe2 <= d_fe2;
            end else if (r_st == S_FIN) begin
                r_fw2 <= 1'b0;
            end
            if (w_dec_go) r_rsp_vld <= 1'b1;
            else if (w_out_acc) r_rsp_vld <= 1'b0;
        end
    end

    // scan trackers: first hit wins; best fit: shortest, then lowest start
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_u_hit <= 1'b0; r_u_slot_ok <= 1'b0;
            r_f_slot_ok <= 1'b0; r_prev_ok <= 1'b0; r_next_ok <= 1'b0;
            r_best_ok <= 1'b0;
        end
        if (r_st == S_USCAN) begin
            if (w_uh.vld && w_uh.start == w_off && !r_u_hit) begin
                r_u_hit <= 1'b1; r_u_idx <= 10'(r_cnt); r_u_len <= w_uh.len;
            end
            if (!w_uh.vld && !r_u_slot_ok) begin
                r_u_slot_ok <= 1'b1; r_u_slot <= 10'(r_cnt);
            end
        end
        if (r_st == S_FSCAN) begin
            if (!w_fh.vld && !r_f_slot_ok) begin
                r_f_slot_ok <= 1'b1; r_f_slot <= 10'(r_cnt);
            end
            if (w_fh.vld && w_fend == w_off && !r_prev_ok) begin
                r_prev_ok <= 1'b1; r_prev <= 10'(r_cnt); r_prev_len <= w_fh.len;
            end
            if (w_fh.vld && w_fh.start == w_off + r_u_len && !r_next_ok) begin
                r_next_ok <= 1'b1; r_next <= 10'(r_cnt); r_next_len <= w_fh.len;
            end
            if (w_fit && w_better) begin
                r_best_ok <= 1'b1; r_best <= 10'(r_cnt);
                r_best_start <= w_fh.start; r_best_len <= w_fh.len;
                r_best_skip <= w_skip;
            end
        end
    end

    `BFRA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready, o_rsp_valid && $stable(o_rsp))
    `BFRA_ASSERT_NEXT(a_dec_to_out, i_clk, i_rst_n, r_st == S_DEC, o_rsp_valid)
    `BFRA_ASSERT_IMP(a_ok_full_range, i_clk, i_rst_n, o_rsp_valid && o_rsp.status != ST_OK, o_rsp.result_offset == 32'd0)
endmodule

@@ hdl/bfra_cell.sv @@
// one storage cell of a table row; rotates its entry to the neighbor on shift
// depends on bfra_pkg
module bfra_cell #(
    parameter int unsigned POS = 0,
    parameter bit INIT_VLD = 1'b0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  bfra_pkg::t_cell_cmd i_cmd,
    input  logic [32:0] i_init_len,
    input  bfra_pkg::t_ent i_prev,
    output bfra_pkg::t_ent o_ent
);
    import bfra_pkg::*;
    t_ent r_ent, n_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_cmd.clr) begin
            n_ent.vld = INIT_VLD;
            n_ent.start = '0;
            n_ent.len = i_init_len;
        end else if (i_cmd.wr && i_cmd.wr_pos == 10'(POS)) begin
            n_ent = i_cmd.wr_ent;
        end else if (i_cmd.shift) begin
            n_ent = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.vld <= INIT_VLD;
            r_ent.start <= '0;
            r_ent.len <= HEAP_RESET;
        end else begin
            r_ent <= n_ent;
        end
    end
    assign o_ent = r_ent;
endmodule

@@ hdl/bfra_row.sv @@
// a ring of storage cells; the entry at cell 0 is presented to the controller
// depends on bfra_pkg, bfra_cell
module bfra_row #(
    parameter int unsigned DEPTH = 64,
    parameter bit INIT_VLD = 1'b0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  bfra_pkg::t_cell_cmd i_cmd,
    input  logic [32:0] i_init_len,
    output bfra_pkg::t_ent o_head
);
    import bfra_pkg::*;
    t_ent w_ent [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bfra_cell #(
            .POS(g),
            .INIT_VLD((g == 0) ? INIT_VLD : 1'b0)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd(i_cmd),
            .i_init_len(i_init_len),
            .i_prev(w_ent[(g + 1) % DEPTH]),
            .o_ent(w_ent[g])
        );
    end
    assign o_head = w_ent[0];
endmodule

@@ test/testbench.sv @@
// self-checking testbench for best_fit_range_allocator: random and directed requests
// with a built-in best-fit predictor. depends on bfra_pkg and the allocator rtl
`timescale 1ns / 100ps

module testbench;
    import bfra_pkg::*;

    localparam int NFREE = 64;
    localparam int NUSED = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_beat = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_beat;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;

    best_fit_range_allocator uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req(req_beat),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp(rsp_beat),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow heap state
    logic [63:0] heap_bytes;
    logic [63:0] fr_start [NFREE];
    logic [63:0] fr_len [NFREE];
    bit fr_vld [NFREE];
    logic [63:0] blk_start [NUSED];
    logic [63:0] blk_len [NUSED];
    bit blk_vld [NUSED];
    logic [63:0] bytes_used;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int errors = 0;
    bit gapless = 0;
    bit hold_trig = 0;

    function automatic void heap_reinit(logic [63:0] size);
        if (size < 16) size = 16;
        if (size > 64'hFFFF_FFF0) size = 64'hFFFF_FFF0;
        heap_bytes = size;
        for (int i = 0; i < NFREE; i++) fr_vld[i] = 0;
        for (int i = 0; i < NUSED; i++) blk_vld[i] = 0;
        fr_start[0] = 0;
        fr_len[0] = size;
        fr_vld[0] = 1;
        bytes_used = 0;
    endfunction

    function automatic int find_free_at(logic [63:0] s);
        for (int i = 0; i < NFREE; i++) if (fr_vld[i] && fr_start[i] == s) return i;
        return -1;
    endfunction

    function automatic int find_free_ending(logic [63:0] e);
        for (int i = 0; i < NFREE; i++)
            if (fr_vld[i] && fr_start[i] + fr_len[i] == e) return i;
        return -1;
    endfunction

    function automatic int empty_free_slot();
        for (int i = 0; i < NFREE; i++) if (!fr_vld[i]) return i;
        return -1;
    endfunction

    function automatic int find_block(logic [63:0] s);
        for (int i = 0; i < NUSED; i++) if (blk_vld[i] && blk_start[i] == s) return i;
        return -1;
    endfunction

    function automatic int empty_block_slot();
        for (int i = 0; i < NUSED; i++) if (!blk_vld[i]) return i;
        return -1;
    endfunction

    function automatic void drop_bytes(logic [63:0] n);
        bytes_used = (n > bytes_used) ? 0 : bytes_used - n;
    endfunction

    function automatic logic [2:0] free_block(logic [63:0] off, output logic [63:0] sz);
        int u, lo, hi, f;
        logic [63:0] len;
        sz = 0;
        if (off >= heap_bytes) return ST_RANGE;
        u = find_block(off);
        if (u < 0) return ST_NOT_ALLOC;
        len = blk_len[u];
        lo = find_free_ending(off);
        hi = find_free_at(off + len);
        if (lo >= 0 && hi >= 0) begin
            fr_len[lo] += len + fr_len[hi];
            fr_vld[hi] = 0;
        end else if (lo >= 0) begin
            fr_len[lo] += len;
        end else if (hi >= 0) begin
            fr_start[hi] = off;
            fr_len[hi] += len;
        end else begin
            f = empty_free_slot();
            if (f < 0) return ST_FULL;
            fr_start[f] = off;
            fr_len[f] = len;
            fr_vld[f] = 1;
        end
        blk_vld[u] = 0;
        drop_bytes(len);
        sz = len;
        return ST_OK;
    endfunction

    function automatic logic [2:0] grant_block(logic [63:0] req, logic [63:0] al,
                                               output logic [63:0] off,
                                               output logic [63:0] sz);
        logic [63:0] need, skip, best_skip, s, tail;
        int best, u, extra;
        off = 0;
        sz = 0;
        if (req == 0 || req > heap_bytes || al == 0 || (al & (al - 1)) != 0)
            return ST_BAD_ARG;
        need = (req + 15) & ~64'd15;
        best = -1;
        best_skip = 0;
        for (int i = 0; i < NFREE; i++) begin
            if (!fr_vld[i] || fr_len[i] < need) continue;
            s = fr_start[i];
            skip = ((s + al - 1) & ~(al - 1)) - s;
            if (fr_len[i] < need + skip) continue;
            if (best < 0 || fr_len[i] < fr_len[best] ||
                (fr_len[i] == fr_len[best] && s < fr_start[best])) begin
                best = i;
                best_skip = skip;
            end
        end
        if (best < 0) return ST_NO_FIT;
        s = fr_start[best];
        tail = fr_len[best] - best_skip - need;
        u = empty_block_slot();
        extra = -1;
        if (u < 0) return ST_FULL;
        if (best_skip > 0 && tail > 0) begin
            extra = empty_free_slot();
            if (extra < 0) return ST_FULL;
        end
        if (best_skip > 0) begin
            fr_len[best] = best_skip;
            if (tail > 0) begin
                fr_start[extra] = s + best_skip + need;
                fr_len[extra] = tail;
                fr_vld[extra] = 1;
            end
        end else if (tail > 0) begin
            fr_start[best] = s + need;
            fr_len[best] = tail;
        end else begin
            fr_vld[best] = 0;
        end
        blk_start[u] = s + best_skip;
        blk_len[u] = need;
        blk_vld[u] = 1;
        bytes_used += need;
        off = s + best_skip;
        sz = need;
        return ST_OK;
    endfunction

    function automatic logic [2:0] resize_block(logic [63:0] off, logic [63:0] size,
                                                output logic [63:0] sz);
        int u, nx, f;
        logic [63:0] old, delta;
        sz = 0;
        if (off >= heap_bytes) return ST_RANGE;
        if (size == 0) return free_block(off, sz);
        u = find_block(off);
        if (u < 0) return ST_NOT_ALLOC;
        old = blk_len[u];
        nx = find_free_at(off + old);
        if (size < old) begin
            delta = old - size;
            if (nx >= 0) begin
                fr_start[nx] = off + size;
                fr_len[nx] += delta;
            end else begin
                f = empty_free_slot();
                if (f < 0) return ST_FULL;
                fr_start[f] = off + size;
                fr_len[f] = delta;
                fr_vld[f] = 1;
            end
            drop_bytes(delta);
        end else if (size > old) begin
            delta = size - old;
            if (nx < 0 || fr_len[nx] < delta) return ST_NO_GROW;
            if (fr_len[nx] == delta) begin
                fr_vld[nx] = 0;
            end else begin
                fr_start[nx] += delta;
                fr_len[nx] -= delta;
            end
            bytes_used += delta;
        end
        blk_len[u] = size;
        sz = size;
        return ST_OK;
    endfunction

    function automatic t_rsp heap_response(t_req r);
        t_rsp o;
        logic [63:0] off, sz;
        logic [2:0] st;
        int u;
        off = 0;
        sz = 0;
        case (r.func)
            FUNC_ALLOC: st = grant_block(r.request_size, r.alignment, off, sz);
            FUNC_RELEASE: st = free_block(r.block_offset, sz);
            FUNC_RESIZE: st = resize_block(r.block_offset, r.request_size, sz);
            default: begin
                if (r.block_offset >= heap_bytes) begin
                    st = ST_RANGE;
                end else begin
                    u = find_block(r.block_offset);
                    if (u < 0) begin
                        st = ST_NOT_ALLOC;
                    end else begin
                        st = ST_OK;
                        sz = blk_len[u];
                    end
                end
            end
        endcase
        if (st != ST_OK) begin
            off = 0;
            sz = 0;
        end
        o.status = st;
        o.result_offset = off[31:0];
        o.block_size = sz[31:0];
        o.used_bytes = bytes_used[31:0];
        return o;
    endfunction

    // driver: one new beat per accept, random gap between beats unless gapless
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (req_valid && req_ready) expected_rsps.push_back(heap_response(req_beat));
            if (req_valid && !req_ready) begin
                // hold the beat
            end else if (send_gap != 0) begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                req_beat <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                send_gap <= gapless ? 0 : $urandom_range(0, 3);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor: checks results, random stalls plus a long hold-off in each pressure phase
    int stall_cnt = 0;
    int hold_cnt = 0;
    bit hold_seen = 0;
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %0h", $time,
                             rsp_beat);
                    errors++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(rsp_beat.status));
                    check_field("result_offset", exp_r.result_offset,
                                rsp_beat.result_offset);
                    check_field("block_size", exp_r.block_size, rsp_beat.block_size);
                    check_field("used_bytes", exp_r.used_bytes, rsp_beat.used_bytes);
                end
            end
            if (hold_trig != hold_seen) begin
                hold_seen <= hold_trig;
                hold_cnt <= LONG_HOLD;
                rsp_ready <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                rsp_ready <= 1'b0;
            end else if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
                rsp_ready <= 1'b0;
            end else if (rsp_valid && rsp_ready && !gapless) begin
                stall_cnt <= $urandom_range(0, 3);
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(logic [1:0] f, logic [31:0] off, logic [31:0] sz,
                            logic [31:0] al);
        t_req r;
        r.func = f;
        r.block_offset = off;
        r.request_size = sz;
        r.alignment = al;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_heap_size(logic [31:0] v);
        drain();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        heap_reinit({32'd0, v});
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        logic [63:0] lim;
        int r;
        lim = heap_bytes / 40 + 1;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 6) return $urandom;
        if (r < 8) return heap_bytes[31:0];
        if (r < 10) return heap_bytes[31:0] + 1;
        if (r < 40) return $urandom_range(1, 64);
        return $urandom_range(1, (lim > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0]);
    endfunction

    function automatic logic [31:0] pick_align();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 6) return $urandom;
        if (r < 10) return 32'd1 << $urandom_range(0, 31);
        if (r < 50) return 1;
        return 32'd1 << $urandom_range(0, 10);
    endfunction

    // offsets mostly name live blocks as the predictor sees them now
    function automatic int pick_live_block();
        int live[$];
        for (int i = 0; i < NUSED; i++) if (blk_vld[i]) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic push_random_req();
        int r, b;
        logic [1:0] f;
        logic [31:0] off, sz;
        r = $urandom_range(0, 99);
        f = (r < 45) ? FUNC_ALLOC : (r < 70) ? FUNC_RELEASE :
            (r < 88) ? FUNC_RESIZE : FUNC_QUERY;
        b = pick_live_block();
        r = $urandom_range(0, 99);
        if (b >= 0 && r < 80) off = blk_start[b][31:0];
        else if (r < 85) off = heap_bytes[31:0];
        else if (r < 90 && b >= 0) off = blk_start[b][31:0] + 16;
        else off = $urandom;
        sz = pick_size();
        if (f == FUNC_RESIZE && b >= 0 && off == blk_start[b][31:0]) begin
            r = $urandom_range(0, 9);
            if (r == 0) sz = 0;
            else if (r == 1) sz = blk_len[b][31:0];
            else if (r < 6) sz = blk_len[b][31:0] + $urandom_range(1, 300);
            else if (blk_len[b] > 1) sz = $urandom_range(1, blk_len[b][31:0] - 1);
        end
        push_req(f, off, sz, pick_align());
    endtask

    task automatic random_phase(int n, bit pressure);
        for (int k = 0; k < n; k++) begin
            while (pending_reqs.size() > 1) @(posedge i_clk);
            push_random_req();
            if (pressure && k == n / 3) hold_trig = ~hold_trig;
            if (pressure && k == (2 * n) / 3) begin
                drain();
                push_random_req();
            end
        end
    endtask

    initial begin
        heap_reinit(64'd1048576);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: arguments, alignment, grow/shrink, merges, range checks
        push_req(FUNC_ALLOC, 0, 100, 1);
        push_req(FUNC_ALLOC, 0, 16, 256);
        push_req(FUNC_ALLOC, 0, 16, 0);
        push_req(FUNC_ALLOC, 0, 16, 3);
        push_req(FUNC_ALLOC, 0, 0, 1);
        push_req(FUNC_ALLOC, 0, 32'hFFFF_FFFF, 1);
        push_req(FUNC_ALLOC, 0, 32, 32'h8000_0000);
        push_req(FUNC_QUERY, 0, 0, 1);
        push_req(FUNC_RESIZE, 0, 50, 1);
        push_req(FUNC_RESIZE, 0, 112, 1);
        push_req(FUNC_RESIZE, 0, 200, 1);
        push_req(FUNC_RESIZE, 0, 2000, 1);
        push_req(FUNC_RESIZE, 0, 200, 1);
        push_req(FUNC_QUERY, 8, 0, 1);
        push_req(FUNC_RELEASE, 32'd1048576, 0, 1);
        push_req(FUNC_QUERY, 32'hFFFF_FFFF, 0, 1);
        push_req(FUNC_RELEASE, 256, 0, 1);
        push_req(FUNC_RESIZE, 0, 0, 1);
        push_req(FUNC_RELEASE, 0, 0, 1);
        push_req(FUNC_ALLOC, 0, 32'd1048576, 1);
        push_req(FUNC_RESIZE, 0, 32'd1048000, 1);
        push_req(FUNC_RELEASE, 0, 0, 1);
        push_req(FUNC_ALLOC, 0, 32'd1048577, 1);
        push_req(FUNC_RESIZE, 32'h7FFF_FFFF, 5, 32'h7FFF_FFFF);
        drain();

        random_phase(450, 1'b1);
        write_heap_size(32'd0);
        random_phase(80, 1'b0);
        write_heap_size(32'd4096);
        random_phase(350, 1'b0);
        write_heap_size(32'hFFFF_FFFF);
        gapless = 1;
        random_phase(250, 1'b0);
        gapless = 0;
        random_phase(150, 1'b0);
        write_heap_size(32'd1048576);
        random_phase(500, 1'b1);
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
